// ===== rtl/ems_pkg.sv =====
// package for the emitter mode sequencer: mode codes, widths and fixed channel masks
`default_nettype none
package ems_pkg;

  localparam int CHANNELS = 16;
  localparam int UB_W     = 16;
  localparam int MODE_W   = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_DISABLED = 3'd0,
    MODE_IDLE     = 3'd1,
    MODE_DEFAULT  = 3'd2,
    MODE_USER     = 3'd3,
    MODE_CYCLING  = 3'd4,
    MODE_ALL940   = 3'd5,
    MODE_ALL660   = 3'd6
  } mode_t;

  // channels that exist within the visible mask bits
  function automatic logic [UB_W-1:0] chan_mask_f();
    logic [UB_W-1:0] m;
    for (int i = 0; i < UB_W; i++) begin
      m[i] = (i < CHANNELS);
    end
    return m;
  endfunction

  localparam logic [UB_W-1:0] CHAN_MASK    = chan_mask_f();
  localparam logic [UB_W-1:0] EVEN_MASK    = 16'h5555 & CHAN_MASK;
  localparam logic [UB_W-1:0] ODD_MASK     = 16'hAAAA & CHAN_MASK;
  localparam logic [UB_W-1:0] DEFAULT_MASK = 16'h6666 & CHAN_MASK;

endpackage
`default_nettype wire

// ===== rtl/ems_if.sv =====
// poll and result channel interfaces of the emitter mode sequencer
`default_nettype none
interface ems_in_if;
  logic                     valid;
  logic                     ready;
  logic                     tick;
  logic                     override_enable;
  logic [ems_pkg::UB_W-1:0] user_bits;
  logic                     enable;
  logic [ems_pkg::MODE_W-1:0] requested_mode;

  modport source (output valid, tick, override_enable, user_bits, enable, requested_mode,
                  input ready);
  modport sink (input valid, tick, override_enable, user_bits, enable, requested_mode,
                output ready);
endinterface

interface ems_out_if;
  logic                       valid;
  logic                       ready;
  logic [ems_pkg::UB_W-1:0]   channel_on;
  logic [ems_pkg::MODE_W-1:0] mode;
  logic                       applied;

  modport source (output valid, channel_on, mode, applied, input ready);
  modport sink (input valid, channel_on, mode, applied, output ready);
endinterface
`default_nettype wire

// ===== rtl/emitter_mode_sequencer.sv =====
// emitter mode sequencer: poll register, mode step logic and result register
//
// usage:
//   in_if  carries one poll request per handshake: tick, override_enable,
//          user_bits, enable and requested_mode
//   out_if returns exactly one result request per poll: the channel on mask,
//          the mode after the poll and whether a step ran (applied)
// timing:
//   a poll is captured in an input register; the step logic runs from that
//   register once the result slot is free or being emptied, and writes the
//   mode state and the result register together
//   one poll per clock is sustained while out_if.ready stays high; the only
//   loop is the update of mode, parity, stored user bits and mask in the step stage
// reset (rst_n low, synchronous):
//   mode goes to disabled, parity, stored user bits and mask clear to zero,
//   both pipeline stages empty
// stall:
//   while out_if.ready is low the result is held; the input register still
//   fills, then in_if.ready drops until the result is taken
`default_nettype none
module emitter_mode_sequencer (
  input  wire       clk,
  input  wire       rst_n,
  ems_in_if.sink    in_if,
  ems_out_if.source out_if
);

  // input register
  logic                       s1_v_r;
  logic                       s1_tick_r;
  logic                       s1_ovr_r;
  logic [ems_pkg::UB_W-1:0]   s1_ubits_r;
  logic                       s1_en_r;
  logic [ems_pkg::MODE_W-1:0] s1_req_r;

  // sequencer state
  ems_pkg::mode_t             mode_r, mode_nxt;
  logic                       parity_r, parity_nxt;
  logic [ems_pkg::UB_W-1:0]   ubits_r;
  logic [ems_pkg::UB_W-1:0]   mask_r, mask_nxt;

  // result register
  logic                       out_v_r;
  logic [ems_pkg::UB_W-1:0]   out_mask_r;
  ems_pkg::mode_t             out_mode_r;
  logic                       out_applied_r;

  logic           s1_adv;
  logic           in_take;
  logic           run;
  ems_pkg::mode_t req;

  // step stage moves when the result slot is free or being emptied
  assign s1_adv  = s1_v_r && (!out_v_r || out_if.ready);
  assign in_if.ready = !s1_v_r || s1_adv;
  assign in_take = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_v_r <= in_if.valid;
    end
    if (in_take) begin
      s1_tick_r  <= in_if.tick;
      s1_ovr_r   <= in_if.override_enable;
      s1_ubits_r <= in_if.user_bits;
      s1_en_r    <= in_if.enable;
      s1_req_r   <= in_if.requested_mode;
    end
  end

  // code seven means nothing and stands for idle
  always_comb begin
    if (s1_req_r > ems_pkg::MODE_W'(ems_pkg::MODE_ALL660)) begin
      req = ems_pkg::MODE_IDLE;
    end else begin
      req = ems_pkg::mode_t'(s1_req_r);
    end
  end

  // step condition: tick, override outside user/cycling, or changed bits in user mode
  always_comb begin
    run = s1_tick_r
       || (s1_ovr_r && mode_r != ems_pkg::MODE_USER && mode_r != ems_pkg::MODE_CYCLING)
       || (s1_ovr_r && mode_r == ems_pkg::MODE_USER && s1_ubits_r != ubits_r);
  end

  // next mode
  always_comb begin
    mode_nxt = mode_r;
    case (mode_r)
      ems_pkg::MODE_DISABLED: begin
        if (s1_en_r || req != mode_r) mode_nxt = ems_pkg::MODE_IDLE;
      end
      ems_pkg::MODE_IDLE: begin
        if (!s1_en_r) mode_nxt = ems_pkg::MODE_DISABLED;
        else if (req != mode_r) mode_nxt = req;
      end
      default: begin
        if (!s1_en_r) mode_nxt = ems_pkg::MODE_DISABLED;
        else if (req != mode_r) mode_nxt = ems_pkg::MODE_IDLE;
      end
    endcase
  end

  // mask from the mode held before the move, with the new parity and user bits
  assign parity_nxt = ~parity_r;

  always_comb begin
    case (mode_r)
      ems_pkg::MODE_DISABLED: mask_nxt = '0;
      ems_pkg::MODE_DEFAULT:  mask_nxt = ems_pkg::DEFAULT_MASK;
      ems_pkg::MODE_USER:     mask_nxt = s1_ubits_r & ems_pkg::CHAN_MASK;
      ems_pkg::MODE_CYCLING:  mask_nxt = parity_nxt ? ems_pkg::ODD_MASK : ems_pkg::EVEN_MASK;
      ems_pkg::MODE_ALL940:   mask_nxt = ems_pkg::EVEN_MASK;
      ems_pkg::MODE_ALL660:   mask_nxt = ems_pkg::ODD_MASK;
      default:                mask_nxt = mask_r;  // idle keeps the pattern
    endcase
  end

  // state update and result capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= ems_pkg::MODE_DISABLED;
      parity_r <= 1'b0;
      ubits_r  <= '0;
      mask_r   <= '0;
      out_v_r  <= 1'b0;
    end else begin
      if (s1_adv && run) begin
        mode_r   <= mode_nxt;
        parity_r <= parity_nxt;
        ubits_r  <= s1_ubits_r;
        mask_r   <= mask_nxt;
      end
      if (s1_adv) begin
        out_v_r <= 1'b1;
      end else if (out_if.ready) begin
        out_v_r <= 1'b0;
      end
    end
    if (s1_adv) begin
      out_mask_r    <= run ? mask_nxt : mask_r;
      out_mode_r    <= run ? mode_nxt : mode_r;
      out_applied_r <= run;
    end
  end

  assign out_if.valid      = out_v_r;
  assign out_if.channel_on = out_mask_r;
  assign out_if.mode       = out_mode_r;
  assign out_if.applied    = out_applied_r;

  // a step out of disabled always leaves every channel off
  a_disabled_off: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && run && mode_r == ems_pkg::MODE_DISABLED |=> mask_r == '0)
    else $error("step from disabled left channels on");

  // disabled only ever moves to idle
  a_disabled_exit: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && mode_r == ems_pkg::MODE_DISABLED
      |=> mode_r == ems_pkg::MODE_DISABLED || mode_r == ems_pkg::MODE_IDLE)
    else $error("disabled moved straight to a working mode");

  // parity flips on every step and holds otherwise
  a_parity: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> (parity_r != $past(parity_r)) == $past(run))
    else $error("parity out of step with applied steps");

  // reported mode matches the state after the request
  a_out_mode: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_if.mode == mode_r && out_if.channel_on == mask_r)
    else $error("result does not match sequencer state");

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// self-checking testbench for the emitter mode sequencer: poll stimulus, mode predictor, result checks
`timescale 1ns / 1ps
module testbench;

  // one poll request as sent to the block
  typedef struct packed {
    logic                       tick;
    logic                       override_enable;
    logic [ems_pkg::UB_W-1:0]   user_bits;
    logic                       enable;
    logic [ems_pkg::MODE_W-1:0] requested_mode;
  } poll_t;

  // one result request as expected back
  typedef struct packed {
    logic [ems_pkg::UB_W-1:0]   channel_on;
    logic [ems_pkg::MODE_W-1:0] mode;
    logic                       applied;
  } emitter_state_t;

  // request code seven has no mode of its own
  localparam logic [ems_pkg::MODE_W-1:0] REQ_UNUSED = 3'd7;

  localparam int RANDOM_POLLS = 1880;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int CALM_FROM    = 800;   // window where neither side idles
  localparam int CALM_TO      = 1400;
  localparam int STALL_AT     = 400;   // long receiver hold-off starts here
  localparam int STALL_LEN    = 300;

  logic clk;
  logic rst_n;

  ems_in_if  poll_ch ();
  ems_out_if result_ch ();

  emitter_mode_sequencer uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (poll_ch),
    .out_if (result_ch)
  );

  // polls waiting to be driven and results the block still owes us
  poll_t          pending_polls[$];
  emitter_state_t expected_results[$];

  // predictor copy of the emitter control state
  ems_pkg::mode_t           held_mode;
  logic                     step_parity;
  logic [ems_pkg::UB_W-1:0] kept_user_bits;
  logic [ems_pkg::UB_W-1:0] channel_mask;

  int unsigned cycle_count;
  int unsigned stall_left;
  int unsigned mismatches;
  int unsigned polls_sent;
  int unsigned results_checked;
  int unsigned steps_seen;
  logic [7:0]  modes_seen;

  // free-running clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // percentage of cycles a side sits idle; zero inside the calm window
  function automatic int idle_pct();
    return (cycle_count >= CALM_FROM && cycle_count < CALM_TO) ? 0 : 20;
  endfunction

  // advance the predicted state by one poll and return what the block should report
  function automatic emitter_state_t step_emitter(poll_t p);
    emitter_state_t             r;
    logic [ems_pkg::MODE_W-1:0] req;
    logic                       run;
    ems_pkg::mode_t             nxt;
    logic [ems_pkg::UB_W-1:0]   even_ch;
    logic [ems_pkg::UB_W-1:0]   odd_ch;
    logic [ems_pkg::UB_W-1:0]   dflt_ch;
    req = (p.requested_mode == REQ_UNUSED) ? ems_pkg::MODE_IDLE : p.requested_mode;
    // a step runs on a tick, on override outside user and cycling, or on
    // override in user mode with fresh user bits
    run = p.tick ||
          (p.override_enable && held_mode != ems_pkg::MODE_USER &&
           held_mode != ems_pkg::MODE_CYCLING) ||
          (p.override_enable && held_mode == ems_pkg::MODE_USER &&
           p.user_bits != kept_user_bits);
    for (int i = 0; i < ems_pkg::UB_W; i++) begin
      even_ch[i] = (i < ems_pkg::CHANNELS) && (i % 2 == 0);
      odd_ch[i]  = (i < ems_pkg::CHANNELS) && (i % 2 == 1);
      dflt_ch[i] = (i < ems_pkg::CHANNELS) && (((i + 1) >> 1) % 2 == 1);
    end
    if (run) begin
      nxt = held_mode;
      case (held_mode)
        ems_pkg::MODE_DISABLED: begin
          if (p.enable || req != ems_pkg::MODE_DISABLED) nxt = ems_pkg::MODE_IDLE;
        end
        ems_pkg::MODE_IDLE: begin
          if (!p.enable) nxt = ems_pkg::MODE_DISABLED;
          else if (req != ems_pkg::MODE_IDLE) nxt = ems_pkg::mode_t'(req);
        end
        default: begin
          if (!p.enable) nxt = ems_pkg::MODE_DISABLED;
          else if (req != held_mode) nxt = ems_pkg::MODE_IDLE;
        end
      endcase
      step_parity    = ~step_parity;
      kept_user_bits = p.user_bits;
      // mask comes from the mode held before the move
      case (held_mode)
        ems_pkg::MODE_DISABLED: channel_mask = '0;
        ems_pkg::MODE_DEFAULT:  channel_mask = dflt_ch;
        ems_pkg::MODE_USER:     channel_mask = kept_user_bits & (even_ch | odd_ch);
        ems_pkg::MODE_CYCLING:  channel_mask = step_parity ? odd_ch : even_ch;
        ems_pkg::MODE_ALL940:   channel_mask = even_ch;
        ems_pkg::MODE_ALL660:   channel_mask = odd_ch;
        default:                channel_mask = channel_mask;  // idle keeps the pattern
      endcase
      held_mode = nxt;
    end
    r.channel_on = channel_mask;
    r.mode       = held_mode;
    r.applied    = run;
    return r;
  endfunction

  function automatic void add_poll(logic tk, logic ovr, logic [ems_pkg::UB_W-1:0] bits,
                                   logic en, logic [ems_pkg::MODE_W-1:0] req);
    poll_t p;
    p.tick            = tk;
    p.override_enable = ovr;
    p.user_bits       = bits;
    p.enable          = en;
    p.requested_mode  = req;
    pending_polls.push_back(p);
  endfunction

  // cycle counter and watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count,
               expected_results.size());
      $display("FAIL");
      $finish;
    end
  end

  // long receiver hold-off, counted here so the sender keeps pushing meanwhile
  always @(posedge clk) begin
    if (cycle_count == STALL_AT) stall_left <= STALL_LEN;
    else if (stall_left != 0) stall_left <= stall_left - 1;
  end

  // driver: a poll that is offered stays put until it is taken
  always @(posedge clk) begin : drive_poll
    poll_t nxt;
    if (!rst_n) begin
      poll_ch.valid <= 1'b0;
    end else begin
      if (poll_ch.valid && poll_ch.ready) begin
        // accepted polls go through the predictor in order
        expected_results.push_back(step_emitter(pending_polls.pop_front()));
        polls_sent++;
      end
      if (!poll_ch.valid || poll_ch.ready) begin
        if (pending_polls.size() != 0 && $urandom_range(99) >= idle_pct()) begin
          nxt = pending_polls[0];
          poll_ch.valid           <= 1'b1;
          poll_ch.tick            <= nxt.tick;
          poll_ch.override_enable <= nxt.override_enable;
          poll_ch.user_bits       <= nxt.user_bits;
          poll_ch.enable          <= nxt.enable;
          poll_ch.requested_mode  <= nxt.requested_mode;
        end else begin
          poll_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure, compare each result with the oldest expectation
  always @(posedge clk) begin : check_result
    emitter_state_t want;
    if (!rst_n) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with no poll outstanding: on=%h mode=%0d applied=%b", $time,
                   result_ch.channel_on, result_ch.mode, result_ch.applied);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (want.applied) steps_seen++;
          modes_seen[want.mode] <= 1'b1;
          if (result_ch.channel_on !== want.channel_on) begin
            $display("%0t: channel_on expected %h got %h", $time, want.channel_on,
                     result_ch.channel_on);
            mismatches++;
          end
          if (result_ch.mode !== want.mode) begin
            $display("%0t: mode expected %0d got %0d", $time, want.mode, result_ch.mode);
            mismatches++;
          end
          if (result_ch.applied !== want.applied) begin
            $display("%0t: applied expected %b got %b", $time, want.applied,
                     result_ch.applied);
            mismatches++;
          end
        end
      end
      result_ch.ready <= (stall_left == 0) && ($urandom_range(99) >= idle_pct());
    end
  end

  initial begin : run_test
    logic [ems_pkg::MODE_W-1:0] req;
    logic [ems_pkg::UB_W-1:0]   bits;
    int                         run_len;
    // every block input known from time zero, reset held low
    rst_n                    = 1'b0;
    poll_ch.valid            = 1'b0;
    poll_ch.tick             = 1'b0;
    poll_ch.override_enable  = 1'b0;
    poll_ch.user_bits        = '0;
    poll_ch.enable           = 1'b0;
    poll_ch.requested_mode   = ems_pkg::MODE_DISABLED;
    result_ch.ready          = 1'b0;
    cycle_count              = 0;
    stall_left               = 0;
    mismatches               = 0;
    polls_sent               = 0;
    results_checked          = 0;
    steps_seen               = 0;
    modes_seen               = '0;
    held_mode                = ems_pkg::MODE_DISABLED;
    step_parity              = 1'b0;
    kept_user_bits           = '0;
    channel_mask             = '0;

    // directed walk through every mode and the corner cases
    add_poll(1'b0, 1'b0, 16'h0000, 1'b1, ems_pkg::MODE_DEFAULT);   // no step: held state echoed
    add_poll(1'b0, 1'b1, 16'h0000, 1'b0, ems_pkg::MODE_DISABLED);  // override while disabled
    add_poll(1'b1, 1'b0, 16'h0000, 1'b1, ems_pkg::MODE_DEFAULT);   // disabled to idle
    add_poll(1'b1, 1'b0, 16'h0000, 1'b1, ems_pkg::MODE_DEFAULT);   // idle to default
    add_poll(1'b1, 1'b0, 16'hFFFF, 1'b1, ems_pkg::MODE_DEFAULT);   // default pattern
    add_poll(1'b1, 1'b0, 16'hFFFF, 1'b1, ems_pkg::MODE_USER);      // back to idle
    add_poll(1'b1, 1'b0, 16'hA5C3, 1'b1, ems_pkg::MODE_USER);      // idle to user
    add_poll(1'b1, 1'b1, 16'h1234, 1'b1, ems_pkg::MODE_USER);      // user pattern
    add_poll(1'b0, 1'b1, 16'h1234, 1'b1, ems_pkg::MODE_USER);      // same user bits: no step
    add_poll(1'b0, 1'b1, 16'hFFFF, 1'b1, ems_pkg::MODE_USER);      // new user bits: step
    add_poll(1'b0, 1'b1, 16'h0000, 1'b1, ems_pkg::MODE_USER);
    add_poll(1'b1, 1'b0, 16'h0000, 1'b1, ems_pkg::MODE_CYCLING);   // user to idle
    add_poll(1'b1, 1'b0, 16'h0000, 1'b1, ems_pkg::MODE_CYCLING);   // idle to cycling
    add_poll(1'b1, 1'b0, 16'h0000, 1'b1, ems_pkg::MODE_CYCLING);
    add_poll(1'b0, 1'b1, 16'h0F0F, 1'b1, ems_pkg::MODE_CYCLING);   // override ignored
    add_poll(1'b1, 1'b0, 16'h0000, 1'b1, ems_pkg::MODE_CYCLING);
    add_poll(1'b1, 1'b0, 16'h0000, 1'b1, ems_pkg::MODE_ALL940);
    add_poll(1'b1, 1'b0, 16'h0000, 1'b1, ems_pkg::MODE_ALL940);
    add_poll(1'b1, 1'b0, 16'h0000, 1'b1, ems_pkg::MODE_ALL940);
    add_poll(1'b1, 1'b0, 16'h0000, 1'b1, ems_pkg::MODE_ALL660);
    add_poll(1'b1, 1'b0, 16'h0000, 1'b1, ems_pkg::MODE_ALL660);
    add_poll(1'b1, 1'b0, 16'h0000, 1'b1, ems_pkg::MODE_ALL660);
    add_poll(1'b1, 1'b0, 16'h0000, 1'b0, ems_pkg::MODE_ALL660);    // enable dropped: disabled
    add_poll(1'b1, 1'b0, 16'h0000, 1'b1, REQ_UNUSED);              // unused code acts as idle
    add_poll(1'b1, 1'b0, 16'h0000, 1'b1, REQ_UNUSED);
    add_poll(1'b1, 1'b0, 16'h0000, 1'b0, ems_pkg::MODE_IDLE);

    // random part: requested mode held for a stretch so the working modes are reached,
    // with occasional enable drops and unused codes as noise
    req = ems_pkg::MODE_DEFAULT;
    bits = '0;
    run_len = 0;
    for (int n = 0; n < RANDOM_POLLS; n++) begin
      if (run_len == 0) begin
        run_len = $urandom_range(40, 4);
        req = ($urandom_range(19) == 0) ? REQ_UNUSED
                                        : ems_pkg::MODE_W'($urandom_range(6));
      end
      run_len--;
      case ($urandom_range(9))
        0, 1, 2, 3: ;                          // keep the previous user bits
        4:          bits = '0;
        5:          bits = '1;
        default:    bits = ems_pkg::UB_W'($urandom);
      endcase
      add_poll($urandom_range(99) < 35, $urandom_range(99) < 40, bits,
               $urandom_range(99) >= 4, req);
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // drain: everything sent and answered, then a few cycles for stray results
    while (pending_polls.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d polls checked, %0d of them ran a step", results_checked, steps_seen);
    $display("modes reached (bit per code): %b, long receiver stall of %0d cycles included",
             modes_seen, STALL_LEN);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== emitter_mode_sequencer.f =====
rtl/ems_pkg.sv
rtl/ems_if.sv
rtl/emitter_mode_sequencer.sv
test/testbench.sv
